>>> sv/gpgs_pkg.sv
package gpgs_pkg;

	// Configuration port geometry.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 31;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INV_TWO_SIG = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_SQRD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE   = 3'd5;

	// Register reset values.
	localparam logic [15:0] RST_AMPLITUDE   = 16'd256;
	localparam logic [15:0] RST_INV_TWO_SIG = 16'd512;
	localparam logic [30:0] RST_CUTOFF_SQRD = 31'd294912;
	localparam logic [15:0] RST_ORIGIN_X    = 16'd0;
	localparam logic [15:0] RST_ORIGIN_Y    = 16'd0;
	localparam logic [14:0] RST_CELL_SIZE   = 15'd26;

	// Operation codes of an input word.
	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_SPLAT = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	localparam logic [1:0] OP_NONE  = 2'd3;

	// exp(-1/16) in Q0.32.
	localparam logic [31:0] EXP_STEP_Q32 = 32'd4034748382;

	// Datapath settings; the user must hold them stable in a splat.
	typedef struct packed {
		logic [15:0] amplitude;
		logic [15:0] inv_two_sigma_sqrd;
		logic [30:0] cutoff_sqrd;
	} gpgs_shape_t;

	// Entry i of the exp table, worked out at elaboration by repeated
	// multiplication of a Q0.32 running value.
	function automatic logic [15:0] exp_value(input int unsigned i);
		logic [95:0] v;
		logic [95:0] q;
		v = 96'(1) << 32;
		for (int unsigned j = 0; j < i; j++) begin
			v = (v * 96'(EXP_STEP_Q32)) >> 32;
		end
		q = (v + 96'h8000) >> 16;
		if (q > 96'd65535) begin
			return 16'hFFFF;
		end
		return q[15:0];
	endfunction

endpackage

>>> sv/gpgs_if.sv
interface gpgs_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         opcode;
	logic signed [15:0] point_x;
	logic signed [15:0] point_y;
	logic [5:0]         cell_row;
	logic [5:0]         cell_col;

	modport source (output valid, output opcode, output point_x, output point_y,
		output cell_row, output cell_col, input ready);
	modport sink (input valid, input opcode, input point_x, input point_y,
		input cell_row, input cell_col, output ready);
endinterface

interface gpgs_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] potential;

	modport source (output valid, output potential, input ready);
	modport sink (input valid, input potential, output ready);
endinterface

>>> sv/gpgs_exp_rom.sv
module gpgs_exp_rom #(
	parameter int EXP_ENTRIES = 256,
	localparam int EXP_W = $clog2(EXP_ENTRIES)
) (
	input  logic             clk,
	input  logic [EXP_W-1:0] idx,
	output logic [15:0]      entry
);

	logic [15:0] rom [EXP_ENTRIES];
	logic [15:0] entry_q;

	for (genvar g = 0; g < EXP_ENTRIES; g++) begin : g_rom
		assign rom[g] = gpgs_pkg::exp_value(g);
	end

	always_ff @(posedge clk) begin
		if (32'(idx) < 32'(EXP_ENTRIES)) begin
			entry_q <= rom[idx];
		end else begin
			entry_q <= 16'd0;
		end
	end

	assign entry = entry_q;

endmodule

>>> sv/gpgs_cell_unit.sv
module gpgs_cell_unit #(
	parameter int POS_W = 44,
	parameter int ADDR_W = 12,
	parameter int EXP_ENTRIES = 256,
	localparam int EXP_W = $clog2(EXP_ENTRIES)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  gpgs_pkg::gpgs_shape_t    shape,
	input  logic                     issue,
	input  logic [ADDR_W-1:0]        addr,
	input  logic signed [POS_W-1:0]  cx,
	input  logic signed [POS_W-1:0]  cy,
	input  logic signed [POS_W-1:0]  px,
	input  logic signed [POS_W-1:0]  py,
	input  logic [15:0]              old_value,
	output logic                     busy,
	output logic                     wr_en,
	output logic [ADDR_W-1:0]        wr_addr,
	output logic [15:0]              wr_data
);

	logic signed [POS_W:0] dx, dy;
	logic [POS_W:0]        adx, ady;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [ADDR_W-1:0] addr_s1, addr_s2, addr_s3, addr_s4, addr_s5, addr_s6;
	logic [15:0] adx_s1, ady_s1;
	logic        far_s1, far_s2;
	logic [31:0] sqx_s2, sqy_s2;
	logic [15:0] old_s2, old_s3, old_s4, old_s5, old_s6;
	logic [32:0] d2_sum;
	logic [30:0] d2_s3;
	logic        hit_s3;
	logic [46:0] k_prod;
	logic [26:0] k_idx;
	logic [EXP_W-1:0] idx_s4;
	logic        ok_s4, ok_s5, ok_s6;
	logic [15:0] entry_s5;
	logic [31:0] p_prod;
	logic [15:0] p_s6;

	// Stage 1: offsets to the cell centre. Anything at 2^16 or beyond in
	// either axis is already past the largest cutoff.
	assign dx  = {px[POS_W-1], px} - {cx[POS_W-1], cx};
	assign dy  = {py[POS_W-1], py} - {cy[POS_W-1], cy};
	assign adx = dx[POS_W] ? (POS_W+1)'(-dx) : (POS_W+1)'(dx);
	assign ady = dy[POS_W] ? (POS_W+1)'(-dy) : (POS_W+1)'(dy);

	assign d2_sum = 33'(sqx_s2) + 33'(sqy_s2);
	assign k_prod = 47'(d2_s3) * 47'(shape.inv_two_sigma_sqrd);
	assign k_idx  = k_prod[46:20];
	assign p_prod = 32'(shape.amplitude) * 32'(entry_s5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= addr;
		adx_s1  <= adx[15:0];
		ady_s1  <= ady[15:0];
		far_s1  <= (|adx[POS_W:16]) || (|ady[POS_W:16]);

		// The grid memory answers the stage-0 read in the next cycle.
		addr_s2 <= addr_s1;
		sqx_s2  <= 32'(adx_s1) * 32'(adx_s1);
		sqy_s2  <= 32'(ady_s1) * 32'(ady_s1);
		far_s2  <= far_s1;
		old_s2  <= old_value;

		addr_s3 <= addr_s2;
		old_s3  <= old_s2;
		d2_s3   <= d2_sum[30:0];
		hit_s3  <= !far_s2 && (d2_sum < 33'(shape.cutoff_sqrd));

		addr_s4 <= addr_s3;
		old_s4  <= old_s3;
		idx_s4  <= k_idx[EXP_W-1:0];
		ok_s4   <= hit_s3 && (k_idx < 27'(EXP_ENTRIES));

		addr_s5 <= addr_s4;
		old_s5  <= old_s4;
		ok_s5   <= ok_s4;

		addr_s6 <= addr_s5;
		old_s6  <= old_s5;
		ok_s6   <= ok_s5;
		p_s6    <= p_prod[31:16];
	end

	gpgs_exp_rom #(
		.EXP_ENTRIES(EXP_ENTRIES)
	) u_exp_rom (
		.clk  (clk),
		.idx  (idx_s4),
		.entry(entry_s5)
	);

	assign busy    = v_s1 || v_s2 || v_s3 || v_s4 || v_s5 || v_s6;
	assign wr_en   = v_s6 && ok_s6 && (p_s6 > old_s6);
	assign wr_addr = addr_s6;
	assign wr_data = p_s6;

endmodule

>>> sv/gpgs_grid_mem.sv
module gpgs_grid_mem #(
	parameter int CELLS = 4096,
	localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [15:0]       wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [15:0]       rdata
);

	logic [15:0] mem_q [CELLS];
	logic [15:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> sv/gaussian_potential_grid_splat_unit.sv
// Channel   Direction  Payload
// in_ch     sink       opcode, point_x, point_y, cell_row, cell_col
// out_ch    source     potential
// cfg_*     write      cfg_index selects one of six registers, cfg_data
//
// A clear word writes the whole grid, one cell written per cycle.
// A splat word walks every cell: the cell pipeline takes one cell per cycle
// through the grid memory's read port and its write port, then drains. A read
// word reads the grid memory on acceptance; that word is registered, then moved
// to out_ch once out_ch is free, and in_ch.ready stays low until then.
// After reset the same clearing sweep runs before in_ch.ready rises. A waiting
// result does not block clear or splat.
module gaussian_potential_grid_splat_unit #(
	parameter int GRID_ROWS = 64,
	parameter int GRID_COLS = 64,
	parameter int EXP_ENTRIES = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	gpgs_in_if.sink                             in_ch,
	gpgs_out_if.source                          out_ch,
	input  logic                                cfg_we,
	input  logic [gpgs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gpgs_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int CELLS  = GRID_ROWS * GRID_COLS;
	localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int ROW_W  = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
	localparam int COL_W  = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
	localparam int DIM_MAX = (GRID_ROWS > GRID_COLS) ? GRID_ROWS : GRID_COLS;
	localparam int POS_W  = 33 + $clog2(DIM_MAX + 1);
	localparam int RA_W   = ADDR_W + 7;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_SPLAT = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_RDOUT = 3'd4;

	logic [2:0]              state_q;
	logic [ADDR_W-1:0]       addr_q;
	logic [ROW_W-1:0]        row_q;
	logic [COL_W-1:0]        col_q;
	logic signed [POS_W-1:0] cx_q, cy_q;
	logic signed [15:0]      px_q, py_q;
	logic                    oob_q;
	logic                    out_valid_q;
	logic [15:0]             potential_q;

	logic [15:0]        amplitude_q;
	logic [15:0]        inv_two_sigma_q;
	logic [30:0]        cutoff_sqrd_q;
	logic signed [15:0] origin_x_q;
	logic signed [15:0] origin_y_q;
	logic [14:0]        cell_size_q;

	gpgs_pkg::gpgs_shape_t shape;
	logic                    in_acc;
	logic                    last_col, last_row;
	logic signed [POS_W-1:0] step;
	logic [RA_W-1:0]         rd_lin;
	logic                    rd_oob;
	logic                    out_free;
	logic                    unit_busy, unit_we;
	logic [ADDR_W-1:0]       unit_waddr;
	logic [15:0]             unit_wdata;
	logic                    mem_we, mem_re;
	logic [ADDR_W-1:0]       mem_waddr, mem_raddr;
	logic [15:0]             mem_wdata, mem_rdata;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign last_col    = (col_q == COL_W'(GRID_COLS - 1));
	assign last_row    = (row_q == ROW_W'(GRID_ROWS - 1));
	assign step        = POS_W'({1'b0, cell_size_q});
	assign rd_lin      = RA_W'(in_ch.cell_row) * RA_W'(GRID_COLS) + RA_W'(in_ch.cell_col);
	assign rd_oob      = (32'(in_ch.cell_row) >= 32'(GRID_ROWS)) ||
		(32'(in_ch.cell_col) >= 32'(GRID_COLS));
	assign out_free    = !out_valid_q || out_ch.ready;

	assign shape.amplitude          = amplitude_q;
	assign shape.inv_two_sigma_sqrd = inv_two_sigma_q;
	assign shape.cutoff_sqrd        = cutoff_sqrd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amplitude_q     <= gpgs_pkg::RST_AMPLITUDE;
			inv_two_sigma_q <= gpgs_pkg::RST_INV_TWO_SIG;
			cutoff_sqrd_q   <= gpgs_pkg::RST_CUTOFF_SQRD;
			origin_x_q      <= gpgs_pkg::RST_ORIGIN_X;
			origin_y_q      <= gpgs_pkg::RST_ORIGIN_Y;
			cell_size_q     <= gpgs_pkg::RST_CELL_SIZE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gpgs_pkg::REG_AMPLITUDE:   amplitude_q     <= cfg_data[15:0];
				gpgs_pkg::REG_INV_TWO_SIG: inv_two_sigma_q <= cfg_data[15:0];
				gpgs_pkg::REG_CUTOFF_SQRD: cutoff_sqrd_q   <= cfg_data[30:0];
				gpgs_pkg::REG_ORIGIN_X:    origin_x_q      <= cfg_data[15:0];
				gpgs_pkg::REG_ORIGIN_Y:    origin_y_q      <= cfg_data[15:0];
				gpgs_pkg::REG_CELL_SIZE:   cell_size_q     <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// Sequencer: clearing sweep, cell walk for a splat, single-cell read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			addr_q  <= '0;
			row_q   <= '0;
			col_q   <= '0;
			cx_q    <= '0;
			cy_q    <= '0;
			px_q    <= '0;
			py_q    <= '0;
			oob_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					if (addr_q == ADDR_W'(CELLS - 1)) begin
						addr_q  <= '0;
						state_q <= ST_IDLE;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						unique case (in_ch.opcode)
							gpgs_pkg::OP_CLEAR: begin
								addr_q  <= '0;
								state_q <= ST_CLEAR;
							end
							gpgs_pkg::OP_SPLAT: begin
								addr_q  <= '0;
								row_q   <= '0;
								col_q   <= '0;
								cx_q    <= POS_W'(origin_x_q);
								cy_q    <= POS_W'(origin_y_q);
								px_q    <= in_ch.point_x;
								py_q    <= in_ch.point_y;
								state_q <= ST_SPLAT;
							end
							gpgs_pkg::OP_READ: begin
								oob_q   <= rd_oob;
								state_q <= ST_RDOUT;
							end
							default: ;
						endcase
					end
				end
				ST_SPLAT: begin
					addr_q <= addr_q + 1'b1;
					if (last_col) begin
						col_q <= '0;
						cx_q  <= POS_W'(origin_x_q);
						row_q <= row_q + 1'b1;
						cy_q  <= cy_q + step;
						if (last_row) begin
							state_q <= ST_DRAIN;
						end
					end else begin
						col_q <= col_q + 1'b1;
						cx_q  <= cx_q + step;
					end
				end
				ST_DRAIN: begin
					if (!unit_busy) begin
						state_q <= ST_IDLE;
					end
				end
				ST_RDOUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_RDOUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RDOUT && out_free) begin
			potential_q <= oob_q ? 16'd0 : mem_rdata;
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.potential = potential_q;

	gpgs_cell_unit #(
		.POS_W      (POS_W),
		.ADDR_W     (ADDR_W),
		.EXP_ENTRIES(EXP_ENTRIES)
	) u_cell_unit (
		.clk      (clk),
		.arst_n   (arst_n),
		.shape    (shape),
		.issue    (state_q == ST_SPLAT),
		.addr     (addr_q),
		.cx       (cx_q),
		.cy       (cy_q),
		.px       (POS_W'(px_q)),
		.py       (POS_W'(py_q)),
		.old_value(mem_rdata),
		.busy     (unit_busy),
		.wr_en    (unit_we),
		.wr_addr  (unit_waddr),
		.wr_data  (unit_wdata)
	);

	// The sweep and the cell pipeline never write in the same cycle.
	assign mem_we    = (state_q == ST_CLEAR) || unit_we;
	assign mem_waddr = (state_q == ST_CLEAR) ? addr_q : unit_waddr;
	assign mem_wdata = (state_q == ST_CLEAR) ? 16'd0 : unit_wdata;
	assign mem_re    = (state_q == ST_SPLAT) || (in_acc && in_ch.opcode == gpgs_pkg::OP_READ);
	assign mem_raddr = (state_q == ST_SPLAT) ? addr_q : rd_lin[ADDR_W-1:0];

	gpgs_grid_mem #(
		.CELLS(CELLS)
	) u_grid_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

endmodule

>>> sv/gpgs_checker.sv
module gpgs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  in_opcode,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] out_potential
);

	// Every word but the unused code keeps the block busy for the next cycle.
	a_busy_after_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_opcode != gpgs_pkg::OP_NONE |=> !in_ready)
		else $error("input ready high straight after a working word");

	// A new result only appears as the answer to a read word that was taken.
	a_result_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && in_opcode == gpgs_pkg::OP_READ, 2))
		else $error("result appeared without a read word");

	// A stalled result keeps its word.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_potential))
		else $error("stalled result changed or vanished");

	// While a result waits, no read word can be taken and still be pending.
	a_read_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_opcode == gpgs_pkg::OP_READ |=> !in_ready)
		else $error("input ready high while a read is being answered");

endmodule

bind gaussian_potential_grid_splat_unit gpgs_checker u_gpgs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_ch.valid),
	.in_ready     (in_ch.ready),
	.in_opcode    (in_ch.opcode),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.out_potential(out_ch.potential)
);

>>> dv/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [gpgs_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [gpgs_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	// A splat sweeps the whole grid and then drains its pipeline.
	localparam int SETTLE_CYCLES = 64 * 64 + 64;
	localparam int CYCLE_LIMIT = 2500000;

	// Mirror of the grid and its settings, advanced once per accepted word.
	class splat_grid_mirror;
		localparam int ROWS = 64;
		localparam int COLS = 64;
		localparam int ENTRIES = 256;

		logic [15:0]        amplitude;
		logic [15:0]        inv_two_sigma_sqrd;
		logic [30:0]        cutoff_sqrd;
		logic signed [15:0] origin_x;
		logic signed [15:0] origin_y;
		logic [14:0]        cell_size;
		logic [15:0]        grid [ROWS*COLS];
		logic [15:0]        exp_lut [ENTRIES];
		logic [15:0]        potentials_due [$];
		int                 mismatch_count;

		function new();
			logic [63:0] v;
			logic [63:0] q;
			amplitude = gpgs_pkg::RST_AMPLITUDE;
			inv_two_sigma_sqrd = gpgs_pkg::RST_INV_TWO_SIG;
			cutoff_sqrd = gpgs_pkg::RST_CUTOFF_SQRD;
			origin_x = gpgs_pkg::RST_ORIGIN_X;
			origin_y = gpgs_pkg::RST_ORIGIN_Y;
			cell_size = gpgs_pkg::RST_CELL_SIZE;
			mismatch_count = 0;
			foreach (grid[i]) grid[i] = '0;
			// Entry i holds exp(-i/16), built from a running Q0.32 product.
			v = 64'd1 << 32;
			for (int i = 0; i < ENTRIES; i++) begin
				q = (v + 64'h8000) >> 16;
				exp_lut[i] = (q > 64'd65535) ? 16'hFFFF : q[15:0];
				v = (v * 64'(gpgs_pkg::EXP_STEP_Q32)) >> 32;
			end
		endfunction

		function void write_register(input logic [gpgs_pkg::CFG_IDX_W-1:0] idx,
				input logic [gpgs_pkg::CFG_DATA_W-1:0] data);
			case (idx)
			gpgs_pkg::REG_AMPLITUDE: amplitude = data[15:0];
			gpgs_pkg::REG_INV_TWO_SIG: inv_two_sigma_sqrd = data[15:0];
			gpgs_pkg::REG_CUTOFF_SQRD: cutoff_sqrd = data[30:0];
			gpgs_pkg::REG_ORIGIN_X: origin_x = data[15:0];
			gpgs_pkg::REG_ORIGIN_Y: origin_y = data[15:0];
			gpgs_pkg::REG_CELL_SIZE: cell_size = data[14:0];
			default: ;
			endcase
		endfunction

		task apply_word(input logic [1:0] op, input logic signed [15:0] px,
				input logic signed [15:0] py, input logic [5:0] row, input logic [5:0] col);
			longint cx;
			longint cy;
			longint dx;
			longint dy;
			longint unsigned d2;
			longint unsigned k;
			longint unsigned idx;
			longint unsigned pot;
			case (op)
			gpgs_pkg::OP_CLEAR: begin
				foreach (grid[i]) grid[i] = '0;
			end
			gpgs_pkg::OP_SPLAT: begin
				for (int r = 0; r < ROWS; r++) begin
					cy = longint'(origin_y) + r * longint'(cell_size);
					dy = longint'(py) - cy;
					if (dy < 0) dy = -dy;
					for (int c = 0; c < COLS; c++) begin
						cx = longint'(origin_x) + c * longint'(cell_size);
						dx = longint'(px) - cx;
						if (dx < 0) dx = -dx;
						d2 = dx * dx + dy * dy;
						if (d2 < 64'(cutoff_sqrd)) begin
							k = d2 * 64'(inv_two_sigma_sqrd);
							idx = k >> 20;
							// Offers beyond the end of the table are worth nothing.
							if (idx < ENTRIES) begin
								pot = (64'(amplitude) * 64'(exp_lut[int'(idx)])) >> 16;
								if (pot > 64'd65535) pot = 64'd65535;
								if (pot[15:0] > grid[r*COLS + c]) grid[r*COLS + c] = pot[15:0];
							end
						end
					end
				end
			end
			gpgs_pkg::OP_READ: begin
				potentials_due.push_back(grid[int'(row)*COLS + int'(col)]);
			end
			default: ;
			endcase
		endtask

		task report_mismatch(input string what);
			$display("mismatch: %s", what);
			mismatch_count++;
		endtask

		task check_potential(input logic [15:0] got);
			logic [15:0] want;
			if (potentials_due.size() == 0) begin
				report_mismatch($sformatf("potential %0d with no read outstanding", got));
			end else begin
				want = potentials_due.pop_front();
				if (got !== want) begin
					report_mismatch($sformatf("potential %0d, predicted %0d", got, want));
				end
			end
		endtask
	endclass

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            cfg_we;
	logic [gpgs_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [gpgs_pkg::CFG_DATA_W-1:0] cfg_data;
	bit                              calm = 1'b0;
	int                              cycle_count = 0;
	int                              aim_row = 32;
	int                              aim_col = 32;
	splat_grid_mirror                mirror;

	gpgs_in_if in_ch();
	gpgs_out_if out_ch();

	gaussian_potential_grid_splat_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Result side: check every accepted word, then choose whether to stall.
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			mirror.check_potential(out_ch.potential);
		end
		out_ch.ready <= calm || ($urandom_range(99) >= 11);
	end

	function automatic logic signed [15:0] sat16(input int v);
		if (v > 32767) return 16'sh7FFF;
		if (v < -32768) return 16'sh8000;
		return 16'(v);
	endfunction

	task automatic send_word(input logic [1:0] op, input logic signed [15:0] px,
			input logic signed [15:0] py, input logic [5:0] row, input logic [5:0] col);
		while (!calm && $urandom_range(99) < 11) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.opcode <= op;
		in_ch.point_x <= px;
		in_ch.point_y <= py;
		in_ch.cell_row <= row;
		in_ch.cell_col <= col;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		mirror.apply_word(op, px, py, row, col);
	endtask

	// Bits above a register's width carry junk; the block must drop them.
	task automatic set_register(input logic [gpgs_pkg::CFG_IDX_W-1:0] idx,
			input logic [gpgs_pkg::CFG_DATA_W-1:0] value);
		logic [gpgs_pkg::CFG_DATA_W-1:0] data;
		data = value;
		case (idx)
		gpgs_pkg::REG_CUTOFF_SQRD: ;
		gpgs_pkg::REG_CELL_SIZE: data[30:15] = 16'($urandom);
		default: data[30:16] = 15'($urandom);
		endcase
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		mirror.write_register(idx, data);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Most splats land on the grid and most reads look near the last one.
	task automatic random_words(input int count);
		int done;
		int sel;
		int jit;
		int pitch;
		logic [1:0] op;
		logic signed [15:0] px;
		logic signed [15:0] py;
		logic [5:0] row;
		logic [5:0] col;
		done = 0;
		while (done < count) begin
			sel = $urandom_range(99);
			px = 16'($urandom);
			py = 16'($urandom);
			row = 6'($urandom);
			col = 6'($urandom);
			if (sel < 5) begin
				op = gpgs_pkg::OP_CLEAR;
			end else if (sel < 35) begin
				op = gpgs_pkg::OP_SPLAT;
				if ($urandom_range(9) < 8) begin
					aim_row = $urandom_range(63);
					aim_col = $urandom_range(63);
					pitch = int'(mirror.cell_size);
					jit = 2 * pitch + 64;
					px = sat16(int'(mirror.origin_x) + aim_col * pitch
						+ int'($urandom_range(2 * jit)) - jit);
					py = sat16(int'(mirror.origin_y) + aim_row * pitch
						+ int'($urandom_range(2 * jit)) - jit);
				end
			end else if (sel < 90) begin
				op = gpgs_pkg::OP_READ;
				if ($urandom_range(9) < 7) begin
					row = 6'(aim_row + int'($urandom_range(6)) - 3);
					col = 6'(aim_col + int'($urandom_range(6)) - 3);
				end
			end else begin
				op = gpgs_pkg::OP_NONE;
			end
			send_word(op, px, py, row, col);
			if (op != gpgs_pkg::OP_NONE) done++;
		end
	endtask

	// Clear and splat words give no result, so the block may still be busy
	// after the last read has come back.
	task automatic drain_and_settle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (mirror.potentials_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		mirror = new();
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= gpgs_pkg::REG_AMPLITUDE;
		cfg_data <= '0;
		in_ch.valid <= 1'b0;
		in_ch.opcode <= gpgs_pkg::OP_CLEAR;
		in_ch.point_x <= '0;
		in_ch.point_y <= '0;
		in_ch.cell_row <= '0;
		in_ch.cell_col <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: cells 26/256 m apart, grid corner at the origin.
		send_word(gpgs_pkg::OP_READ, 16'sd0, 16'sd0, 6'd0, 6'd0);
		send_word(gpgs_pkg::OP_NONE, 16'shFFFF, 16'shFFFF, 6'd63, 6'd63);
		send_word(gpgs_pkg::OP_SPLAT, 16'sd0, 16'sd0, 6'd0, 6'd0);
		send_word(gpgs_pkg::OP_READ, 16'sd0, 16'sd0, 6'd0, 6'd0);
		send_word(gpgs_pkg::OP_READ, 16'sd0, 16'sd0, 6'd0, 6'd1);
		send_word(gpgs_pkg::OP_READ, 16'sd0, 16'sd0, 6'd1, 6'd1);
		send_word(gpgs_pkg::OP_SPLAT, 16'sh7FFF, 16'sh7FFF, 6'd0, 6'd0);
		send_word(gpgs_pkg::OP_SPLAT, 16'sh8000, 16'sh8000, 6'd0, 6'd0);
		send_word(gpgs_pkg::OP_SPLAT, 16'sd832, 16'sd832, 6'd0, 6'd0);
		send_word(gpgs_pkg::OP_READ, 16'sd0, 16'sd0, 6'd32, 6'd32);
		send_word(gpgs_pkg::OP_READ, 16'sd0, 16'sd0, 6'd32, 6'd31);
		send_word(gpgs_pkg::OP_READ, 16'sd0, 16'sd0, 6'd40, 6'd32);
		send_word(gpgs_pkg::OP_SPLAT, 16'sd845, 16'sd819, 6'd0, 6'd0);
		send_word(gpgs_pkg::OP_READ, 16'sd0, 16'sd0, 6'd32, 6'd32);
		send_word(gpgs_pkg::OP_READ, 16'sd0, 16'sd0, 6'd33, 6'd32);
		send_word(gpgs_pkg::OP_SPLAT, -16'sd100, 16'sd1700, 6'd0, 6'd0);
		send_word(gpgs_pkg::OP_READ, 16'sd0, 16'sd0, 6'd63, 6'd0);
		send_word(gpgs_pkg::OP_READ, 16'sd0, 16'sd0, 6'd63, 6'd63);
		send_word(gpgs_pkg::OP_CLEAR, 16'sd0, 16'sd0, 6'd0, 6'd0);
		send_word(gpgs_pkg::OP_READ, 16'sd0, 16'sd0, 6'd32, 6'd32);
		send_word(gpgs_pkg::OP_READ, 16'sd0, 16'sd0, 6'd0, 6'd0);
		send_word(gpgs_pkg::OP_SPLAT, 16'sd1638, 16'sd1638, 6'd0, 6'd0);
		send_word(gpgs_pkg::OP_READ, 16'sd0, 16'sd0, 6'd63, 6'd63);
		random_words(15);
		drain_and_settle();

		// Full amplitude with no fall-off, inside a one metre cutoff.
		calm = 1'b1;
		set_register(gpgs_pkg::REG_AMPLITUDE, 31'd65535);
		set_register(gpgs_pkg::REG_INV_TWO_SIG, 31'd0);
		set_register(gpgs_pkg::REG_CUTOFF_SQRD, 31'd65536);
		set_register(gpgs_pkg::REG_ORIGIN_X, 31'h0000FC18);
		set_register(gpgs_pkg::REG_ORIGIN_Y, 31'h0000FC18);
		set_register(gpgs_pkg::REG_CELL_SIZE, 31'd40);
		set_register(REG_SPARE_LO, 31'h7FFFFFFF);
		random_words(16);
		drain_and_settle();
		calm = 1'b0;

		set_register(gpgs_pkg::REG_AMPLITUDE, 31'd0);
		set_register(gpgs_pkg::REG_INV_TWO_SIG, 31'd65535);
		set_register(gpgs_pkg::REG_CUTOFF_SQRD, 31'h7FFFFFFF);
		set_register(gpgs_pkg::REG_ORIGIN_X, 31'h00008000);
		set_register(gpgs_pkg::REG_ORIGIN_Y, 31'h00008000);
		set_register(gpgs_pkg::REG_CELL_SIZE, 31'd32767);
		set_register(REG_SPARE_HI, 31'd0);
		random_words(12);
		drain_and_settle();

		// Steep fall-off on a fine grid: most cells run past the table.
		set_register(gpgs_pkg::REG_AMPLITUDE, 31'd40000);
		set_register(gpgs_pkg::REG_ORIGIN_X, 31'h00007FFF);
		set_register(gpgs_pkg::REG_ORIGIN_Y, 31'h0000FF00);
		set_register(gpgs_pkg::REG_CELL_SIZE, 31'd1);
		random_words(11);
		drain_and_settle();
		set_register(gpgs_pkg::REG_ORIGIN_X, 31'd0);
		set_register(gpgs_pkg::REG_ORIGIN_Y, 31'd0);
		random_words(11);
		drain_and_settle();

		// Every cell centre sits on the origin.
		set_register(gpgs_pkg::REG_AMPLITUDE, 31'd1000);
		set_register(gpgs_pkg::REG_INV_TWO_SIG, 31'd300);
		set_register(gpgs_pkg::REG_CUTOFF_SQRD, 31'd300000);
		set_register(gpgs_pkg::REG_ORIGIN_X, 31'h000001F4);
		set_register(gpgs_pkg::REG_ORIGIN_Y, 31'h0000FE0C);
		set_register(gpgs_pkg::REG_CELL_SIZE, 31'd0);
		random_words(14);
		drain_and_settle();

		set_register(gpgs_pkg::REG_AMPLITUDE, 31'($urandom));
		set_register(gpgs_pkg::REG_INV_TWO_SIG, 31'($urandom_range(2000)));
		set_register(gpgs_pkg::REG_CUTOFF_SQRD, 31'($urandom));
		set_register(gpgs_pkg::REG_ORIGIN_X, 31'($urandom));
		set_register(gpgs_pkg::REG_ORIGIN_Y, 31'($urandom));
		set_register(gpgs_pkg::REG_CELL_SIZE, 31'($urandom_range(300)));
		random_words(14);
		drain_and_settle();

		// A zero cutoff leaves every cell untouched.
		set_register(gpgs_pkg::REG_AMPLITUDE, 31'd256);
		set_register(gpgs_pkg::REG_INV_TWO_SIG, 31'd512);
		set_register(gpgs_pkg::REG_CUTOFF_SQRD, 31'd0);
		set_register(gpgs_pkg::REG_ORIGIN_X, 31'd0);
		set_register(gpgs_pkg::REG_ORIGIN_Y, 31'd0);
		set_register(gpgs_pkg::REG_CELL_SIZE, 31'd26);
		random_words(12);
		drain_and_settle();

		if (mirror.mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
